@@ sv/chte_pkg.sv @@
// Shared constants, codes and types for the chained hash table engine.
package chte_pkg;

   // Table geometry and field widths.
   localparam int BUCKETS     = 64;
   localparam int CHAIN_DEPTH = 4;
   localparam int KEY_BITS    = 32;
   localparam int VALUE_BITS  = 32;
   localparam int SLOTS       = BUCKETS * CHAIN_DEPTH;

   localparam int OPCODE_BITS = 2;
   localparam int STATUS_BITS = 2;
   localparam int BUCKET_BITS = $clog2(BUCKETS);
   localparam int SLOT_BITS   = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
   localparam int COUNT_BITS  = $clog2(SLOTS + 1);

   // Request operations.
   typedef enum logic [OPCODE_BITS-1:0] {
      OP_ADD      = 2'd0,
      OP_FIND     = 2'd1,
      OP_RETRIEVE = 2'd2,
      OP_REMOVE   = 2'd3
   } opcode_type;

   // Result status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic {
      CS_IDLE   = 1'b0,
      CS_LOOKUP = 1'b1
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } chte_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_held;
   } chte_sts_type;

   // One bucket row of the entry memory.
   typedef struct packed {
      logic [CHAIN_DEPTH-1:0][KEY_BITS-1:0]   keys;
      logic [CHAIN_DEPTH-1:0][VALUE_BITS-1:0] values;
   } row_type;

endpackage

@@ sv/chte_ctrl.sv @@
// Controller state machine that sequences request capture and bucket update.
module chte_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  chte_pkg::chte_sts_type sts,
   output chte_pkg::chte_cmd_type cmd
);
   import chte_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: a transfer starts a lookup, which ends once the result is stored.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) state_in = CS_LOOKUP;
         end
         CS_LOOKUP: begin
            if (!sts.out_held) state_in = CS_IDLE;
         end
      endcase
   end

   // Outputs: requests are taken only in idle, and the update runs when the
   // output register is free.
   always_comb begin
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         CS_LOOKUP: begin
            cmd.execute = !sts.out_held;
         end
      endcase
   end

   // A captured request is always followed by a lookup cycle.
   a_capture_to_lookup: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == CS_LOOKUP)
      else $error("capture not followed by lookup");

   // The update never runs while the result register is held.
   a_no_execute_when_held: assert property (@(posedge clock) disable iff (reset)
      sts.out_held |-> !cmd.execute)
      else $error("update ran while result held");

   // Requests are never taken during a lookup.
   a_no_capture_in_lookup: assert property (@(posedge clock) disable iff (reset)
      state_ff == CS_LOOKUP |-> !cmd.capture && req_stall)
      else $error("request taken during lookup");

endmodule

@@ sv/chte_datapath.sv @@
// Datapath with the bucket memory, valid bits, live count and result register.
module chte_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  chte_pkg::chte_cmd_type              cmd,
   output chte_pkg::chte_sts_type              sts,
   input  logic [chte_pkg::OPCODE_BITS-1:0]    req_opcode,
   input  logic [chte_pkg::KEY_BITS-1:0]       req_key,
   input  logic [chte_pkg::VALUE_BITS-1:0]     req_value,
   input  logic [chte_pkg::BUCKET_BITS-1:0]    req_bucket,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [chte_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [chte_pkg::VALUE_BITS-1:0]     rsp_value_out,
   output logic [chte_pkg::COUNT_BITS-1:0]     rsp_item_count
);
   import chte_pkg::*;

   // Captured request.
   opcode_type             op_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [VALUE_BITS-1:0]  value_ff;
   logic [BUCKET_BITS-1:0] bucket_ff;

   // Bucket memory and its registered read row.
   row_type bucket_mem_ff [BUCKETS];
   row_type rd_row_ff;
   row_type wr_row;
   logic    mem_we;

   // Slot valid bits and live count.
   logic [BUCKETS-1:0][CHAIN_DEPTH-1:0] valid_ff;
   logic [BUCKETS-1:0][CHAIN_DEPTH-1:0] valid_in;
   logic [CHAIN_DEPTH-1:0]              row_valid;
   logic [COUNT_BITS-1:0]               count_ff;
   logic [COUNT_BITS-1:0]               count_in;

   // Chain search results.
   logic                 hit_found;
   logic [SLOT_BITS-1:0] hit_idx;
   logic                 free_found;
   logic [SLOT_BITS-1:0] free_idx;

   // Result register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   status_type            rsp_status_ff;
   status_type            status_in;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic [VALUE_BITS-1:0] vout_in;
   logic [COUNT_BITS-1:0] rsp_count_ff;

   // Capture the request and read its bucket row on the input transfer.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= opcode_type'(req_opcode);
         key_ff    <= req_key;
         value_ff  <= req_value;
         bucket_ff <= req_bucket;
         rd_row_ff <= bucket_mem_ff[req_bucket];
      end
   end

   // Write the updated row back on a successful add.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bucket_mem_ff[bucket_ff] <= wr_row;
      end
   end

   // Search the chain for the first matching key and the first free slot.
   always_comb begin
      row_valid  = valid_ff[bucket_ff];
      hit_found  = 1'b0;
      hit_idx    = '0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = CHAIN_DEPTH - 1; i >= 0; i--) begin
         if (row_valid[i] && rd_row_ff.keys[i] == key_ff) begin
            hit_found = 1'b1;
            hit_idx   = SLOT_BITS'(i);
         end
         if (!row_valid[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_BITS'(i);
         end
      end
   end

   // Apply the operation to the row, valid bits and count.
   always_comb begin
      wr_row    = rd_row_ff;
      mem_we    = 1'b0;
      valid_in  = valid_ff;
      count_in  = count_ff;
      status_in = ST_MISS;
      vout_in   = '0;
      unique case (op_ff)
         OP_ADD: begin
            if (hit_found) begin
               status_in = ST_MISS;
            end else if (!free_found) begin
               status_in = ST_FULL;
            end else begin
               status_in                  = ST_OK;
               wr_row.keys[free_idx]      = key_ff;
               wr_row.values[free_idx]    = value_ff;
               mem_we                     = cmd.execute;
               valid_in[bucket_ff][free_idx] = 1'b1;
               count_in                   = count_ff + 1'b1;
            end
         end
         OP_FIND: begin
            if (hit_found) status_in = ST_OK;
         end
         OP_RETRIEVE: begin
            if (hit_found) begin
               status_in = ST_OK;
               vout_in   = rd_row_ff.values[hit_idx];
            end
         end
         OP_REMOVE: begin
            if (hit_found) begin
               status_in                    = ST_OK;
               vout_in                      = rd_row_ff.values[hit_idx];
               valid_in[bucket_ff][hit_idx] = 1'b0;
               if (count_ff != '0) count_in = count_ff - 1'b1;
            end
         end
      endcase
   end

   // Table state updates only when the operation executes.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (cmd.execute) begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   // Result valid: set on execute, cleared by an output transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_status_ff <= status_in;
         rsp_value_ff  <= vout_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign sts.out_held   = rsp_valid_ff && rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_value_out  = rsp_value_ff;
   assign rsp_item_count = rsp_count_ff;

   // The live count never exceeds the number of slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(SLOTS))
      else $error("live count beyond slot total");

   // Table state is untouched between operations.
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !cmd.execute |=> $stable(count_ff) && $stable(valid_ff))
      else $error("table state changed without an operation");

   // A remove that hits frees exactly one entry.
   a_remove_dec: assert property (@(posedge clock) disable iff (reset)
      cmd.execute && op_ff == OP_REMOVE && hit_found
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("remove hit did not decrement count");

   // A result appears only after an executed operation.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.execute))
      else $error("result without operation");

endmodule

@@ sv/chained_hash_table_engine.sv @@
// Top level of the chained hash table engine: controller plus datapath.
// The transfer cycle of a request reads the whole bucket row (all chain slots)
// from the single-port bucket memory into a register, and the update then
// compares the chain, writes the row back on a successful add and loads the
// result register; a new request is taken only after that update. A new request
// may be taken while the previous result still waits in the output register;
// its update then waits until that result has been transferred. Valid bits
// reset at once, so no clearing pass is needed.
module chained_hash_table_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [chte_pkg::OPCODE_BITS-1:0]    req_opcode,
   input  logic [chte_pkg::KEY_BITS-1:0]       req_key,
   input  logic [chte_pkg::VALUE_BITS-1:0]     req_value,
   input  logic [chte_pkg::BUCKET_BITS-1:0]    req_bucket,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [chte_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [chte_pkg::VALUE_BITS-1:0]     rsp_value_out,
   output logic [chte_pkg::COUNT_BITS-1:0]     rsp_item_count
);
   import chte_pkg::*;

   chte_cmd_type cmd;
   chte_sts_type sts;

   // Sequencing.
   chte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage and operation logic.
   chte_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_opcode     (req_opcode),
      .req_key        (req_key),
      .req_value      (req_value),
      .req_bucket     (req_bucket),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_value_out  (rsp_value_out),
      .rsp_item_count (rsp_item_count)
   );

endmodule

@@ tb/chte_table_checker.sv @@
// Checker for the chained hash table engine: shadow table, result prediction and compare.
module chte_table_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [chte_pkg::OPCODE_BITS-1:0]    req_opcode,
   input  logic [chte_pkg::KEY_BITS-1:0]       req_key,
   input  logic [chte_pkg::VALUE_BITS-1:0]     req_value,
   input  logic [chte_pkg::BUCKET_BITS-1:0]    req_bucket,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [chte_pkg::STATUS_BITS-1:0]    rsp_status,
   input  logic [chte_pkg::VALUE_BITS-1:0]     rsp_value_out,
   input  logic [chte_pkg::COUNT_BITS-1:0]     rsp_item_count,
   output int                                  error_count,
   output int                                  results_owed
);
   import chte_pkg::*;

   // One predicted result transfer.
   typedef struct {
      status_type                status;
      logic [VALUE_BITS-1:0]     value_out;
      logic [COUNT_BITS-1:0]     item_count;
   } table_result_type;

   // Shadow copy of the entry memory and the live entry count.
   logic [KEY_BITS-1:0]   shadow_keys   [SLOTS];
   logic [VALUE_BITS-1:0] shadow_values [SLOTS];
   logic                  shadow_used   [SLOTS];
   int                    shadow_count;

   // Predicted results, oldest first.
   table_result_type      expected_results [$];
   table_result_type      oldest;

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      error_count++;
   endtask

   // Scan the named bucket, apply the request to the shadow table and return its result.
   function automatic table_result_type apply_request(
      input opcode_type            op,
      input logic [KEY_BITS-1:0]   key,
      input logic [VALUE_BITS-1:0] value,
      input logic [BUCKET_BITS-1:0] bucket
   );
      int               base;
      int               hit;
      int               free_slot;
      int               s;
      table_result_type res;
      base      = (int'(bucket) % BUCKETS) * CHAIN_DEPTH;
      hit       = -1;
      free_slot = -1;
      res.status    = ST_MISS;
      res.value_out = '0;
      for (int i = 0; i < CHAIN_DEPTH; i++) begin
         s = base + i;
         if (shadow_used[s]) begin
            if (hit < 0 && shadow_keys[s] == key) hit = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      unique case (op)
         OP_ADD: begin
            if (hit >= 0) begin
               res.status = ST_MISS;
            end else if (free_slot < 0) begin
               res.status = ST_FULL;
            end else begin
               // A new key takes the lowest free slot of its bucket.
               s = base + free_slot;
               shadow_keys[s]   = key;
               shadow_values[s] = value;
               shadow_used[s]   = 1'b1;
               shadow_count++;
               res.status = ST_OK;
            end
         end
         OP_FIND: begin
            if (hit >= 0) res.status = ST_OK;
         end
         OP_RETRIEVE: begin
            if (hit >= 0) begin
               res.status    = ST_OK;
               res.value_out = shadow_values[base + hit];
            end
         end
         default: begin
            if (hit >= 0) begin
               s = base + hit;
               res.status    = ST_OK;
               res.value_out = shadow_values[s];
               shadow_used[s] = 1'b0;
               if (shadow_count > 0) shadow_count--;
            end
         end
      endcase
      res.item_count = COUNT_BITS'(shadow_count);
      return res;
   endfunction

   // Watch both channels. A result is compared before the request of the same edge is
   // predicted, since a result always belongs to an older request.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) shadow_used[i] = 1'b0;
         shadow_count = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result transfer with no request outstanding");
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_status !== oldest.status)
                  report_mismatch($sformatf("status expected %0d got %0d",
                                            oldest.status, rsp_status));
               if (rsp_value_out !== oldest.value_out)
                  report_mismatch($sformatf("value_out expected %h got %h",
                                            oldest.value_out, rsp_value_out));
               if (rsp_item_count !== oldest.item_count)
                  report_mismatch($sformatf("item_count expected %0d got %0d",
                                            oldest.item_count, rsp_item_count));
            end
         end
         if (req_valid && !req_stall)
            expected_results.insert(expected_results.size(),
                                    apply_request(opcode_type'(req_opcode), req_key,
                                                  req_value, req_bucket));
      end
      results_owed = expected_results.size();
   end

endmodule

@@ tb/tb_chained_hash_table_engine.sv @@
// Testbench top for the chained hash table engine: clock, reset, stimulus and verdict.
module tb_chained_hash_table_engine;
   import chte_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 300;
   localparam int HOT_KEYS    = 12;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_valid  = 1'b0;
   logic [OPCODE_BITS-1:0]  req_opcode = '0;
   logic [KEY_BITS-1:0]     req_key    = '0;
   logic [VALUE_BITS-1:0]   req_value  = '0;
   logic [BUCKET_BITS-1:0]  req_bucket = '0;
   logic                    rsp_stall  = 1'b0;
   logic                    req_stall;
   logic                    rsp_valid;
   logic [STATUS_BITS-1:0]  rsp_status;
   logic [VALUE_BITS-1:0]   rsp_value_out;
   logic [COUNT_BITS-1:0]   rsp_item_count;

   int                      error_count;
   int                      results_owed;
   int                      cycle_count  = 0;
   logic                    send_burst   = 1'b0;
   logic                    take_burst   = 1'b0;
   logic                    hold_results = 1'b0;
   logic [KEY_BITS-1:0]     hot_keys  [HOT_KEYS];
   logic [KEY_BITS-1:0]     fill_keys [SLOTS];

   // Free-running clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   chained_hash_table_engine u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_key        (req_key),
      .req_value      (req_value),
      .req_bucket     (req_bucket),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_value_out  (rsp_value_out),
      .rsp_item_count (rsp_item_count)
   );

   chte_table_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_key        (req_key),
      .req_value      (req_value),
      .req_bucket     (req_bucket),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_value_out  (rsp_value_out),
      .rsp_item_count (rsp_item_count),
      .error_count    (error_count),
      .results_owed   (results_owed)
   );

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result side: stall a random number of cycles before each transfer, with runs of
   // no stalling and one long hold-off on request.
   initial begin : result_taker
      int wait_cycles;
      forever begin
         if ($urandom_range(0, 29) == 0) take_burst = !take_burst;
         if (hold_results) begin
            wait_cycles  = LONG_HOLD;
            hold_results = 1'b0;
         end else begin
            wait_cycles = take_burst ? 0 : $urandom_range(0, 6);
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Offer one request after a random gap and hold it until its transfer. Valid stays
   // high after the transfer so back-to-back requests need no second assignment.
   task automatic offer_request(
      input opcode_type             op,
      input logic [KEY_BITS-1:0]    key,
      input logic [VALUE_BITS-1:0]  value,
      input logic [BUCKET_BITS-1:0] bucket
   );
      int gap;
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_key    <= key;
      req_value  <= value;
      req_bucket <= bucket;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering and wait until every outstanding result has been transferred.
   task automatic hold_until_drained;
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   // Adds and removes dominate so buckets fill and empty often.
   function automatic opcode_type pick_op;
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return OP_ADD;
      if (r < 55) return OP_FIND;
      if (r < 75) return OP_RETRIEVE;
      return OP_REMOVE;
   endfunction

   // Mostly a small key set on a few buckets, so that hits, duplicates and full buckets
   // are common; the rest is random keys on random buckets.
   task automatic random_request;
      logic [KEY_BITS-1:0]    key;
      logic [BUCKET_BITS-1:0] bucket;
      int                     idx;
      if ($urandom_range(0, 4) == 0) begin
         key    = $urandom;
         bucket = BUCKET_BITS'($urandom_range(0, BUCKETS - 1));
      end else begin
         key = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
         // Sometimes flip one bit, so that a key one bit away from a hot key is tried.
         if ($urandom_range(0, 19) == 0) begin
            idx      = $urandom_range(0, KEY_BITS - 1);
            key[idx] = ~key[idx];
         end
         bucket      = BUCKET_BITS'($urandom_range(0, 7));
         bucket[5:3] = $urandom_range(0, 1) ? 3'b111 : 3'b000;
      end
      offer_request(pick_op(), key, $urandom, bucket);
   endtask

   // Stimulus and verdict.
   initial begin
      hot_keys[0] = '0;
      hot_keys[1] = '1;
      for (int i = 2; i < HOT_KEYS; i++) hot_keys[i] = $urandom;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table misses, filling a bucket with extreme keys and values,
      // full and duplicate adds, the same key in another bucket, slot reuse after remove.
      offer_request(OP_FIND,     32'h0000_0000, $urandom,      6'd0);
      offer_request(OP_RETRIEVE, 32'h0000_0000, $urandom,      6'd0);
      offer_request(OP_REMOVE,   32'h0000_0000, $urandom,      6'd0);
      offer_request(OP_ADD,      32'h0000_0000, 32'hFFFF_FFFF, 6'd0);
      offer_request(OP_ADD,      32'hFFFF_FFFF, 32'h0000_0000, 6'd0);
      offer_request(OP_ADD,      32'h0000_0001, 32'h1234_5678, 6'd0);
      offer_request(OP_ADD,      32'h8000_0000, 32'h8000_0001, 6'd0);
      offer_request(OP_ADD,      32'h0000_0005, 32'h5555_AAAA, 6'd0);
      offer_request(OP_ADD,      32'hFFFF_FFFF, 32'h0000_0123, 6'd0);
      offer_request(OP_FIND,     32'hFFFF_FFFF, $urandom,      6'd0);
      offer_request(OP_RETRIEVE, 32'h0000_0000, $urandom,      6'd0);
      offer_request(OP_FIND,     32'h0000_0000, $urandom,      6'd63);
      offer_request(OP_ADD,      32'h0000_0000, 32'hA5A5_A5A5, 6'd63);
      offer_request(OP_REMOVE,   32'h0000_0001, $urandom,      6'd0);
      offer_request(OP_ADD,      32'h0000_0007, 32'h7777_7777, 6'd0);
      offer_request(OP_REMOVE,   32'h0000_0001, $urandom,      6'd0);
      offer_request(OP_RETRIEVE, 32'h0000_0007, $urandom,      6'd0);
      offer_request(OP_REMOVE,   32'h0000_0000, $urandom,      6'd63);
      offer_request(OP_RETRIEVE, 32'h0000_0000, $urandom,      6'd63);
      offer_request(OP_ADD,      32'h0000_0000, 32'h0BAD_0BAD, 6'd0);
      offer_request(OP_REMOVE,   32'h0000_0000, $urandom,      6'd0);
      offer_request(OP_REMOVE,   32'hFFFF_FFFF, $urandom,      6'd0);
      offer_request(OP_REMOVE,   32'h8000_0000, $urandom,      6'd0);
      offer_request(OP_REMOVE,   32'h0000_0007, $urandom,      6'd0);
      offer_request(OP_FIND,     32'h0000_0007, $urandom,      6'd0);
      hold_until_drained();

      // Random mix, with one long result hold-off and one full drain along the way.
      for (int n = 0; n < 900; n++) begin
         if (n == 300) hold_results = 1'b1;
         if (n == 600) hold_until_drained();
         random_request();
      end

      // Fill every slot of the table, then push adds into the full table.
      for (int b = 0; b < BUCKETS; b++) begin
         for (int s = 0; s < CHAIN_DEPTH; s++) begin
            fill_keys[b * CHAIN_DEPTH + s] = $urandom;
            offer_request(OP_ADD, fill_keys[b * CHAIN_DEPTH + s], $urandom,
                          BUCKET_BITS'(b));
         end
      end
      for (int n = 0; n < 16; n++)
         offer_request(OP_ADD, $urandom, $urandom,
                       BUCKET_BITS'($urandom_range(0, BUCKETS - 1)));

      // Remove the fill keys again from the top bucket down.
      for (int i = SLOTS - 1; i >= 0; i--)
         offer_request(OP_REMOVE, fill_keys[i], $urandom, BUCKET_BITS'(i / CHAIN_DEPTH));

      hold_until_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
